// File: hdl/fvg_pkg.sv
// Package for the FAT12/FAT16 volume geometry block: constants, codes and pipeline types.
// Used by hdl/fat_volume_geometry.sv; depends on nothing else.
package fvg_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned DIR_PER_SECTOR = SECTOR_BYTES / 32;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  // boot record flavours
  localparam logic [1:0] BOOT_DOS1 = 2'd0;
  localparam logic [1:0] BOOT_EXT  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FAT12 = 2'd1;
  localparam logic [1:0] ERR_FAT16 = 2'd2;
  localparam logic [1:0] ERR_SMALL = 2'd3;

  localparam logic [15:0] DOS1_MAX_CLUS  = 16'h03FE;
  localparam logic [15:0] EXT12_MAX_CLUS = 16'h03FD;
  localparam logic [15:0] FAT12_MAX_CLUS = 16'h0FF4;
  localparam logic [15:0] FAT16_MAX_CLUS = 16'hFFF4;

  localparam logic [31:0] FAT16_MIN_REQ  = 32'h0001_0000;
  localparam logic [31:0] EXT_SMALL_REQ  = 32'h0000_8000;
  localparam logic [31:0] FLOPPY_MAX_REQ = 32'd1440;
  localparam logic [23:0] FAT12_LIMIT    = 24'h01_0000;
  localparam logic [23:0] FAT16_LIMIT    = 24'h80_0000;

  localparam logic [9:0] ENTS_FAT12 = 10'd112;
  localparam logic [9:0] ENTS_FAT16 = 10'd512;
  localparam logic [5:0] FSTART_FAT12 = 6'(1 + 112 / DIR_PER_SECTOR);
  localparam logic [5:0] FSTART_FAT16 = 6'(1 + 512 / DIR_PER_SECTOR);

  localparam logic [7:0] MEDIA_F0 = 8'hF0;
  localparam logic [7:0] MEDIA_F8 = 8'hF8;
  localparam logic [7:0] MEDIA_F9 = 8'hF9;

  typedef enum logic [1:0] {
    PATH_BAND,
    PATH_FAT12,
    PATH_FAT16
  } path_t;

  typedef struct packed {
    logic [1:0]  boot_type;
    logic [31:0] sector_count;
  } req_t;

  typedef struct packed {
    path_t       path;
    logic [2:0]  sh;
    logic [15:0] maxc;
    logic [5:0]  fstart;
    logic [31:0] n;
    logic [15:0] est;
    logic [8:0]  spf;
    logic [10:0] ds;
    logic [15:0] cl;
    logic [9:0]  ents;
    logic [7:0]  desc;
    logic [5:0]  heads;
    logic [4:0]  hidden;
    logic        too_small;
  } geo_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic        is_fat16;
    logic [17:0] data_start;
    logic [16:0] root_start;
    logic [4:0]  hidden_sectors;
    logic [5:0]  head_count;
    logic [7:0]  media_descriptor;
    logic [9:0]  root_entries;
    logic [15:0] fat_sectors;
    logic [7:0]  cluster_sectors;
    logic [23:0] total_sectors;
  } res_t;

endpackage

// File: hdl/fat_volume_geometry.sv
// FAT12/FAT16 volume geometry: top level, a five-stage pipeline from request to layout.
// Depends on hdl/fvg_pkg.sv.

// One request per clock cycle while the master side accepts results; four register
// stages lie behind the input register: cluster size and FAT estimate, FAT size,
// cluster count, final total and errors.
// Each stage holds its item only while the next one is full and stalled, so bubbles
// are squeezed out and the slave side keeps accepting while any stage is free.
module fat_volume_geometry
  import fvg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,  // boot_type[1:0], sector_count[33:2], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata   // total_sectors[23:0], cluster_sectors[31:24],
                                 // fat_sectors[47:32], root_entries[57:48],
                                 // media_descriptor[65:58], head_count[71:66],
                                 // hidden_sectors[76:72], root_start[93:77],
                                 // data_start[111:94], is_fat16[112],
                                 // error_code[114:113], zero pad
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;
  req_t s1;
  geo_t s2, s3, s4;
  geo_t s2_next, s3_next, s4_next;
  res_t s5, s5_next;

  logic [31:0] est_raw;
  logic [31:0] cl_raw;
  logic [31:0] dsec;
  logic [17:0] spf_acc;
  logic [17:0] three_est;
  logic [23:0] n_out;
  logic [16:0] root_start;

  assign r5 = !v5 || m_tready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;
  assign m_tvalid = v5;
  assign m_tdata  = {5'b0, s5};

  // cluster size, band values and FAT estimate
  always_comb begin
    s2_next = '0;
    s2_next.n = s1.sector_count;
    s2_next.desc = MEDIA_F0;
    if (s1.boot_type == BOOT_EXT && s1.sector_count > FAT16_MIN_REQ) begin
      s2_next.path = PATH_FAT16;
      s2_next.maxc = FAT16_MAX_CLUS;
      s2_next.fstart = FSTART_FAT16;
      s2_next.ents = ENTS_FAT16;
      priority if (s1.sector_count <= 32'h0004_0000) s2_next.sh = 3'd2;
      else if (s1.sector_count <= 32'h0008_0000) s2_next.sh = 3'd3;
      else if (s1.sector_count <= 32'h0010_0000) s2_next.sh = 3'd4;
      else if (s1.sector_count <= 32'h0020_0000) s2_next.sh = 3'd5;
      else if (s1.sector_count <= 32'h0040_0000) s2_next.sh = 3'd6;
      else s2_next.sh = 3'd7;
    end else if (s1.boot_type == BOOT_EXT ||
                 (s1.boot_type == BOOT_DOS1 && s1.sector_count > FLOPPY_MAX_REQ)) begin
      s2_next.path = PATH_FAT12;
      s2_next.fstart = FSTART_FAT12;
      s2_next.ents = ENTS_FAT12;
      if (s1.boot_type == BOOT_EXT) begin
        // small extended volumes get a lower maximum cluster count
        s2_next.maxc = (s1.sector_count <= EXT_SMALL_REQ) ? EXT12_MAX_CLUS : FAT12_MAX_CLUS;
        priority if (s1.sector_count <= 32'h0000_1000) s2_next.sh = 3'd2;
        else if (s1.sector_count <= 32'h0000_2000) s2_next.sh = 3'd3;
        else if (s1.sector_count <= 32'h0000_4000) s2_next.sh = 3'd4;
        else if (s1.sector_count <= 32'h0000_8000) s2_next.sh = 3'd5;
        else s2_next.sh = 3'd4;
      end else begin
        s2_next.maxc = DOS1_MAX_CLUS;
        priority if (s1.sector_count <= 32'h0000_0800) s2_next.sh = 3'd1;
        else if (s1.sector_count <= 32'h0000_1000) s2_next.sh = 3'd2;
        else if (s1.sector_count <= 32'h0000_2000) s2_next.sh = 3'd3;
        else if (s1.sector_count <= 32'h0000_4000) s2_next.sh = 3'd4;
        else if (s1.sector_count <= 32'h0000_8000) s2_next.sh = 3'd5;
        else s2_next.sh = 3'd6;
      end
    end else begin
      s2_next.path = PATH_BAND;
      s2_next.heads = 6'd2;
      s2_next.hidden = 5'd1;
      s2_next.ents = 10'd256;
      s2_next.spf = 9'd12;
      priority if (s1.sector_count > 32'd32732) begin
        s2_next.heads = 6'd32;
        s2_next.hidden = 5'd16;
        s2_next.sh = 3'd4;
        if (s1.sector_count > 32'd65535) s2_next.n = 32'd65535;
      end else if (s1.sector_count > 32'd16388) begin
        s2_next.sh = 3'd3;
      end else if (s1.sector_count > 32'd8212) begin
        s2_next.sh = 3'd2;
      end else if (s1.sector_count > 32'd4126) begin
        s2_next.sh = 3'd1;
      end else if (s1.sector_count > 32'd2880) begin
        s2_next.sh = 3'd1;
        s2_next.spf = 9'd6;
        s2_next.ents = 10'd224;
      end else if (s1.sector_count > 32'd1440) begin
        s2_next.sh = 3'd1;
        s2_next.spf = 9'd5;
        s2_next.ents = ENTS_FAT12;
      end else if (s1.sector_count > 32'd720) begin
        s2_next.sh = 3'd1;
        s2_next.spf = 9'd3;
        s2_next.ents = ENTS_FAT12;
        s2_next.desc = MEDIA_F9;
        s2_next.n = 32'd1440;
      end else begin
        s2_next.heads = 6'd1;
        s2_next.sh = 3'd1;
        s2_next.spf = 9'd2;
        s2_next.ents = ENTS_FAT12;
        s2_next.desc = MEDIA_F8;
        s2_next.n = 32'd720;
      end
    end
    est_raw = (s1.sector_count - {26'b0, s2_next.fstart}) >> s2_next.sh;
    s2_next.est = (est_raw > {16'b0, s2_next.maxc}) ? s2_next.maxc : est_raw[15:0];
    s2_next.too_small = (s2_next.path == PATH_FAT12) &&
                        (s1.sector_count < {26'b0, s2_next.fstart});
  end

  // FAT size and data start
  always_comb begin
    s3_next = s2;
    three_est = {2'b0, s2.est} + {1'b0, s2.est, 1'b0} + 18'd7;
    if (s2.path == PATH_FAT16) begin
      spf_acc = {1'b0, s2.est, 1'b0} + 18'(2 * 2 + SECTOR_BYTES - 1);
    end else begin
      spf_acc = {1'b0, three_est[17:1]} + 18'(SECTOR_BYTES - 1);
    end
    if (s2.path != PATH_BAND) begin
      s3_next.spf = spf_acc[SECTOR_SHIFT +: 9];
    end
    s3_next.ds = {5'b0, s3_next.fstart} + {1'b0, s3_next.spf, 1'b0};
  end

  // cluster count
  always_comb begin
    s4_next = s3;
    dsec = s3.n - {21'b0, s3.ds};
    cl_raw = dsec >> s3.sh;
    s4_next.cl = (cl_raw > {16'b0, s3.maxc}) ? s3.maxc : cl_raw[15:0];
    if (s3.path == PATH_FAT12 && s3.n < {21'b0, s3.ds}) s4_next.too_small = 1'b1;
  end

  // trimmed total, error checks and result
  always_comb begin
    if (s4.path == PATH_BAND) begin
      n_out = s4.n[23:0];
    end else begin
      n_out = {13'b0, s4.ds} + ({8'b0, s4.cl} << s4.sh);
    end
    root_start = 17'd1 + {7'b0, s4.spf, 1'b0};
    s5_next.total_sectors = n_out;
    s5_next.cluster_sectors = 8'd1 << s4.sh;
    s5_next.fat_sectors = {7'b0, s4.spf};
    s5_next.root_entries = s4.ents;
    s5_next.media_descriptor = s4.desc;
    s5_next.head_count = s4.heads;
    s5_next.hidden_sectors = s4.hidden;
    s5_next.root_start = root_start;
    s5_next.data_start = {1'b0, root_start} + {12'b0, s4.ents[9:4]};
    s5_next.is_fat16 = (s4.path == PATH_FAT16);
    priority if (s4.too_small) s5_next.error_code = ERR_SMALL;
    else if (s4.path != PATH_FAT16 && n_out >= FAT12_LIMIT) s5_next.error_code = ERR_FAT12;
    else if (s4.path == PATH_FAT16 && n_out > FAT16_LIMIT) s5_next.error_code = ERR_FAT16;
    else s5_next.error_code = ERR_NONE;
    if (s5_next.error_code != ERR_NONE) begin
      s5_next = '0;
      priority if (s4.too_small) s5_next.error_code = ERR_SMALL;
      else if (s4.path != PATH_FAT16) s5_next.error_code = ERR_FAT12;
      else s5_next.error_code = ERR_FAT16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) s1 <= req_t'({s_tdata[1:0], s_tdata[33:2]});
    if (r2) s2 <= s2_next;
    if (r3) s3 <= s3_next;
    if (r4) s4 <= s4_next;
    if (r5) s5 <= s5_next;
  end

endmodule
